>>> rtl/newton_sqrt_distance_unit_assert.svh
// Assertion macros for the distance unit.
// Each expects clk and rst in scope.
`ifndef NEWTON_SQRT_DISTANCE_UNIT_ASSERT_SVH
`define NEWTON_SQRT_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define NSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nsd assertion failed");

// next-cycle implication
`define NSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nsd assertion failed");

`endif

>>> rtl/nsd_pkg.sv
package nsd_pkg;

  // fraction bits added to the dividend: q = (a << Q_SHIFT) / t
  localparam int unsigned Q_SHIFT = 8;

endpackage

>>> rtl/nsd_div_stage.sv
// One restoring division step: one quotient bit per stage.
module nsd_div_stage #(
  parameter int DIST_BITS = 33,
  parameter int DIV_BITS  = 41
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DIST_BITS-1:0] in_a,
  input  logic [DIST_BITS-1:0] in_t,
  input  logic [DIST_BITS-1:0] in_rem,
  input  logic [DIV_BITS-1:0]  in_num,
  output logic                 out_valid,
  output logic [DIST_BITS-1:0] out_a,
  output logic [DIST_BITS-1:0] out_t,
  output logic [DIST_BITS-1:0] out_rem,
  output logic [DIV_BITS-1:0]  out_num
);

  logic [DIST_BITS:0]   shifted;
  logic [DIST_BITS:0]   diff;
  logic                 ge;
  logic [DIST_BITS-1:0] rem_next;
  logic [DIV_BITS-1:0]  num_next;

  always_comb begin
    shifted  = {in_rem, in_num[DIV_BITS-1]};
    ge       = (shifted >= {1'b0, in_t});
    diff     = shifted - {1'b0, in_t};
    rem_next = ge ? diff[DIST_BITS-1:0] : shifted[DIST_BITS-1:0];
    // dividend bits leave at the top, quotient bits enter at the bottom
    num_next = {in_num[DIV_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a   <= in_a;
      out_t   <= in_t;
      out_rem <= rem_next;
      out_num <= num_next;
    end
  end

endmodule

>>> rtl/nsd_square.sv
// Squared distance in two stages: differences, then squares and sum.
module nsd_square #(
  parameter int COORD_BITS = 16,
  parameter int DIST_BITS  = 2 * COORD_BITS + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] origin_x,
  input  logic signed [COORD_BITS-1:0] origin_y,
  input  logic signed [COORD_BITS-1:0] target_x,
  input  logic signed [COORD_BITS-1:0] target_y,
  output logic                         out_valid,
  output logic [DIST_BITS-1:0]         out_a
);

  logic                        diff_valid;
  logic signed [COORD_BITS:0]  dx;
  logic signed [COORD_BITS:0]  dy;
  logic signed [COORD_BITS:0]  dx_next;
  logic signed [COORD_BITS:0]  dy_next;
  logic signed [2*COORD_BITS+1:0] sq_x;
  logic signed [2*COORD_BITS+1:0] sq_y;
  logic [2*COORD_BITS+1:0]        sum;

  always_comb begin
    dx_next = (COORD_BITS + 1)'(origin_x) - (COORD_BITS + 1)'(target_x);
    dy_next = (COORD_BITS + 1)'(origin_y) - (COORD_BITS + 1)'(target_y);
    sq_x    = (2 * COORD_BITS + 2)'(dx) * (2 * COORD_BITS + 2)'(dx);
    sq_y    = (2 * COORD_BITS + 2)'(dy) * (2 * COORD_BITS + 2)'(dy);
    sum     = unsigned'(sq_x) + unsigned'(sq_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      diff_valid <= in_valid;
      out_valid  <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= dx_next;
      dy    <= dy_next;
      out_a <= sum[DIST_BITS-1:0];
    end
  end

endmodule

>>> rtl/nsd_newton_step.sv
// One Newton step t' = (t + (a << Q_SHIFT) / t) >> 1.
// DIV_BITS division stages followed by one averaging stage.
module nsd_newton_step #(
  parameter int DIST_BITS = 33,
  parameter int DIV_BITS  = 41
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DIST_BITS-1:0] in_a,
  input  logic [DIST_BITS-1:0] in_t,
  output logic                 out_valid,
  output logic [DIST_BITS-1:0] out_a,
  output logic [DIST_BITS-1:0] out_t
);

  logic [DIV_BITS:0]    vld;
  logic [DIST_BITS-1:0] a_s   [DIV_BITS+1];
  logic [DIST_BITS-1:0] t_s   [DIV_BITS+1];
  logic [DIST_BITS-1:0] rem_s [DIV_BITS+1];
  logic [DIV_BITS-1:0]  num_s [DIV_BITS+1];

  logic [DIV_BITS-1:0]  quot;
  logic [DIV_BITS:0]    sum;

  assign vld[0]   = in_valid;
  assign a_s[0]   = in_a;
  assign t_s[0]   = in_t;
  assign rem_s[0] = '0;
  assign num_s[0] = {in_a, {nsd_pkg::Q_SHIFT{1'b0}}};

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    nsd_div_stage #(
      .DIST_BITS(DIST_BITS),
      .DIV_BITS (DIV_BITS)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vld[i]),
      .in_a     (a_s[i]),
      .in_t     (t_s[i]),
      .in_rem   (rem_s[i]),
      .in_num   (num_s[i]),
      .out_valid(vld[i+1]),
      .out_a    (a_s[i+1]),
      .out_t    (t_s[i+1]),
      .out_rem  (rem_s[i+1]),
      .out_num  (num_s[i+1])
    );
  end

  always_comb begin
    // zero divisor only arises for a zero distance; quotient taken as zero
    quot = (t_s[DIV_BITS] == '0) ? '0 : num_s[DIV_BITS];
    sum  = {1'b0, quot} + (DIV_BITS + 1)'(t_s[DIV_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_a <= a_s[DIV_BITS];
      out_t <= sum[DIST_BITS:1];
    end
  end

endmodule

>>> rtl/newton_sqrt_distance_unit.sv
// Euclidean distance between two points, square root by Newton steps.
// Input stream (s_*): one word per query, four signed Q12.4 coordinates.
// Output stream (m_*): one word per query, the distance in unsigned Q.8,
// in the same order as the queries came in.
// Pipeline from acceptance to m_tvalid: two squaring stages, then per
// Newton step DIST_BITS + 8 restoring division stages, one quotient bit
// per stage, and one averaging stage, then the output register.
// Throughput: one query per cycle while the receiver keeps up.
// Stall: with m_tvalid high and m_tready low, the next finished word drops
// into a skid register; once that is full the whole pipe freezes and
// s_tready goes low. Nothing is dropped or repeated. s_tready returns the
// cycle after the held word is taken.
// Reset (rst, synchronous): all valid bits clear, the pipe is empty and
// s_tready is high in the first cycle after reset.
// Coincident points give zero. Large distances are not fully converged
// after NEWTON_STEPS steps; the value is the iterate, not the true root.
module newton_sqrt_distance_unit #(
  parameter int NEWTON_STEPS = 10,
  parameter int COORD_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // origin_x, origin_y, target_x, target_y (low to high), zero padded
  input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // distance (low bits), zero padded
  output logic [((2 * COORD_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  `include "newton_sqrt_distance_unit_assert.svh"

  localparam int DIST_BITS = 2 * COORD_BITS + 1;
  localparam int DIV_BITS  = DIST_BITS + nsd_pkg::Q_SHIFT;
  localparam int OUT_W     = ((DIST_BITS + 7) / 8) * 8;

  // pipe-wide advance; only the skid register can hold it back
  logic en;

  logic [NEWTON_STEPS:0] vld;
  logic [DIST_BITS-1:0]  a_s [NEWTON_STEPS+1];
  logic [DIST_BITS-1:0]  t_s [NEWTON_STEPS+1];

  logic                 out_valid;
  logic [DIST_BITS-1:0] out_dist;
  logic                 skid_valid;
  logic [DIST_BITS-1:0] skid_dist;
  logic                 pop;

  assign en       = !skid_valid;
  assign s_tready = en;

  nsd_square #(
    .COORD_BITS(COORD_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_tvalid),
    .origin_x (s_tdata[COORD_BITS-1:0]),
    .origin_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
    .target_x (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .target_y (s_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .out_valid(vld[0]),
    .out_a    (a_s[0])
  );

  // iterate starts at t = a
  assign t_s[0] = a_s[0];

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
    nsd_newton_step #(
      .DIST_BITS(DIST_BITS),
      .DIV_BITS (DIV_BITS)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (vld[k]),
      .in_a     (a_s[k]),
      .in_t     (t_s[k]),
      .out_valid(vld[k+1]),
      .out_a    (a_s[k+1]),
      .out_t    (t_s[k+1])
    );
  end

  // output register plus skid register
  assign pop = out_valid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_dist   <= skid_dist;
        skid_valid <= 1'b0;
      end
    end else if (vld[NEWTON_STEPS]) begin
      if (!out_valid || pop) begin
        out_dist  <= t_s[NEWTON_STEPS];
        out_valid <= 1'b1;
      end else begin
        skid_dist  <= t_s[NEWTON_STEPS];
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_dist);

  // a word waits in the skid register only behind a held output word
  `NSD_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid)
  // the skid register fills only when the output was stalled
  `NSD_ASSERT_IMPL(a_skid_fill_on_stall, $rose(skid_valid), $past(out_valid && !m_tready))
  // a held skid word is never lost while the receiver stalls
  `NSD_ASSERT_NEXT(a_skid_hold, skid_valid && !m_tready, skid_valid && m_tvalid)

endmodule
